FILE: rtl/core/vtae_pkg.sv
// shared types and constants for the vector terminal address encoder
package vtae_pkg;

    // tag bits that the terminal uses to tell the address bytes apart
    localparam logic [6:0] SEL_HI  = 7'h20;
    localparam logic [6:0] SEL_LOY = 7'h60;
    localparam logic [6:0] SEL_LOX = 7'h40;
    localparam logic [6:0] PAD_BYTE = 7'h00;

    // squared move distance thresholds, one pad byte per threshold reached
    localparam logic [12:0] PAD_TH1 = 13'd41;
    localparam logic [12:0] PAD_TH2 = 13'd369;
    localparam logic [12:0] PAD_TH3 = 13'd1024;
    localparam logic [12:0] PAD_TH4 = 13'd2008;

    // "none sent" marks held in the previous-part registers after reset
    localparam logic [5:0] NONE_SENT6 = 6'h3F;
    localparam logic [4:0] NONE_SENT5 = 5'h1F;

    // byte slots in emission order
    localparam int SLOT_HIGH_Y = 0;
    localparam int SLOT_EXTRA  = 1;
    localparam int SLOT_LOW_Y  = 2;
    localparam int SLOT_HIGH_X = 3;
    localparam int SLOT_LOW_X  = 4;
    localparam int NUM_SLOTS   = 5;

    // one classified point, handed from the front to the back
    typedef struct packed {
        logic [4:0]           high_y;
        logic [3:0]           extra;
        logic [4:0]           low_y;
        logic [4:0]           high_x;
        logic [4:0]           low_x;
        logic [NUM_SLOTS-1:0] slot_mask;
        logic [2:0]           pads;
    } cmd_t;

endpackage

FILE: rtl/core/vector_terminal_address_encoder_top.sv
// top level of the vector terminal graph-mode address encoder
//
// input channel: in_valid/in_ready carry one point (x_coord, y_coord), 12 bits each
// output channel: out_valid/out_ready carry one terminal byte (out_byte) per request,
//   last_byte marks the final byte of a point
// each point gives 1 to 5 address bytes (changed high y, extra, low y, high x, and
//   always low x) followed by 0 to 4 zero pad bytes scaled to the length of the move
// the front classifies a point in the cycle it is taken and writes a command into a
//   short queue (QUEUE_DEPTH entries); the back turns commands into bytes
// path: the first byte of a point passes through a queue entry and then the output register
// throughput: one byte per cycle on the output while out_ready is high, so the 1 to 9
//   bytes of a point leave one after another through the single output register
// the front takes a new point whenever the queue has room, also while bytes of
//   earlier points are still waiting
// reset: the terminal copies of all parts are marked none sent, so the first point
//   sends every address byte and pads for a move from minus one
// output stall: the byte register holds, the back stops, the queue fills and then
//   in_ready drops until the receiver takes bytes again
module vector_terminal_address_encoder_top #(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] x_coord,
    input  logic [11:0] y_coord,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [6:0]  out_byte,
    output logic        last_byte
);

    // front to queue
    logic           q_push;
    logic           q_full;
    vtae_pkg::cmd_t front_cmd;

    // queue to back
    logic           q_pop;
    logic           q_not_empty;
    vtae_pkg::cmd_t q_head;

    vtae_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .x_coord  (x_coord),
        .y_coord  (y_coord),
        .full     (q_full),
        .push     (q_push),
        .cmd      (front_cmd)
    );

    vtae_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (front_cmd),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (q_head)
    );

    // byte sequencer with the output register
    vtae_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (q_not_empty),
        .head      (q_head),
        .pop       (q_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

endmodule

FILE: rtl/core/vtae_front.sv
// front end: splits a point, decides which bytes to send and the pad count
module vtae_front
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [11:0]      x_coord,
    input  logic [11:0]      y_coord,
    input  logic             full,
    output logic             push,
    output vtae_pkg::cmd_t   cmd
);

    logic [5:0] prev_hx_reg;
    logic [5:0] prev_hy_reg;
    logic [5:0] prev_ly_reg;
    logic [4:0] prev_ex_reg;

    logic [4:0] hx;
    logic [4:0] hy;
    logic [4:0] lx;
    logic [4:0] ly;
    logic [3:0] ex;
    logic       hx_chg;
    logic       hy_chg;
    logic       ly_chg;
    logic       ex_chg;

    logic signed [6:0]  dx;
    logic signed [6:0]  dy;
    logic signed [13:0] dx_w;
    logic signed [13:0] dy_w;
    logic [13:0]        dx_sq;
    logic [13:0]        dy_sq;
    logic [12:0]        dist_sq;
    logic [vtae_pkg::NUM_SLOTS-1:0] mask;

    assign hx = x_coord[11:7];
    assign lx = x_coord[6:2];
    assign hy = y_coord[11:7];
    assign ly = y_coord[6:2];
    assign ex = {y_coord[1:0], x_coord[1:0]};

    assign hx_chg = {1'b0, hx} != prev_hx_reg;
    assign hy_chg = {1'b0, hy} != prev_hy_reg;
    assign ly_chg = {1'b0, ly} != prev_ly_reg;
    assign ex_chg = {1'b0, ex} != prev_ex_reg;

    // move of the high parts; "none sent" counts as -1
    assign dx    = signed'({2'b00, hx}) - signed'({prev_hx_reg[5], prev_hx_reg});
    assign dy    = signed'({2'b00, hy}) - signed'({prev_hy_reg[5], prev_hy_reg});
    assign dx_w  = 14'(dx);
    assign dy_w  = 14'(dy);
    assign dx_sq = unsigned'(dx_w * dx_w);
    assign dy_sq = unsigned'(dy_w * dy_w);
    assign dist_sq = {1'b0, dx_sq[11:0]} + {1'b0, dy_sq[11:0]};

    always_comb
    begin
        mask = '0;
        mask[vtae_pkg::SLOT_HIGH_Y] = hy_chg;
        mask[vtae_pkg::SLOT_LOW_X]  = 1'b1;
        if (hx_chg)
        begin
            mask[vtae_pkg::SLOT_EXTRA]  = ex_chg;
            mask[vtae_pkg::SLOT_LOW_Y]  = 1'b1;
            mask[vtae_pkg::SLOT_HIGH_X] = 1'b1;
        end
        else if (ex_chg)
        begin
            mask[vtae_pkg::SLOT_EXTRA] = 1'b1;
            mask[vtae_pkg::SLOT_LOW_Y] = 1'b1;
        end
        else
        begin
            mask[vtae_pkg::SLOT_LOW_Y] = ly_chg;
        end
    end

    always_comb
    begin
        cmd.high_y    = hy;
        cmd.extra     = ex;
        cmd.low_y     = ly;
        cmd.high_x    = hx;
        cmd.low_x     = lx;
        cmd.slot_mask = mask;
        cmd.pads      = 3'(dist_sq >= vtae_pkg::PAD_TH1) + 3'(dist_sq >= vtae_pkg::PAD_TH2)
                      + 3'(dist_sq >= vtae_pkg::PAD_TH3) + 3'(dist_sq >= vtae_pkg::PAD_TH4);
    end

    assign in_ready = !full;
    assign push     = in_valid && in_ready;

    // after any point the terminal holds exactly its parts, so the copies follow the input
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_hx_reg <= vtae_pkg::NONE_SENT6;
            prev_hy_reg <= vtae_pkg::NONE_SENT6;
            prev_ly_reg <= vtae_pkg::NONE_SENT6;
            prev_ex_reg <= vtae_pkg::NONE_SENT5;
        end
        else if (push)
        begin
            prev_hx_reg <= {1'b0, hx};
            prev_hy_reg <= {1'b0, hy};
            prev_ly_reg <= {1'b0, ly};
            prev_ex_reg <= {1'b0, ex};
        end
    end

    a_state_real_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        push |=> (!prev_hx_reg[5] && !prev_hy_reg[5] && !prev_ly_reg[5] && !prev_ex_reg[4]))
        else $error("previous-part copy still marked none sent after a request");

endmodule

FILE: rtl/core/vtae_queue.sv
// short command queue between the front and the back
module vtae_queue #(
    parameter int DEPTH = 2
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  vtae_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output vtae_pkg::cmd_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    vtae_pkg::cmd_t   entries [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign head      = entries[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("queue read while empty");

endmodule

FILE: rtl/core/vtae_back.sv
// back end: walks one command byte by byte into the output register
module vtae_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           not_empty,
    input  vtae_pkg::cmd_t head,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_ready,
    output logic [6:0]     out_byte,
    output logic           last_byte
);

    logic                           started_reg;
    logic [vtae_pkg::NUM_SLOTS-1:0] mask_reg;
    logic [2:0]                     pads_reg;
    logic                           out_valid_reg;
    logic [6:0]                     out_byte_reg;
    logic                           last_byte_reg;

    logic [vtae_pkg::NUM_SLOTS-1:0] work_mask;
    logic [2:0]                     work_pads;
    logic [vtae_pkg::NUM_SLOTS-1:0] pick;
    logic [vtae_pkg::NUM_SLOTS-1:0] rem_mask;
    logic [2:0]                     rem_pads;
    logic                           is_pad;
    logic                           done;
    logic                           load;
    logic [6:0]                     byte_next;

    // remaining work of the head command, fresh from the queue on its first byte
    assign work_mask = started_reg ? mask_reg : head.slot_mask;
    assign work_pads = started_reg ? pads_reg : head.pads;

    assign pick     = work_mask & (~work_mask + 1'b1);
    assign is_pad   = work_mask == '0;
    assign rem_mask = work_mask & ~pick;
    assign rem_pads = is_pad ? work_pads - 3'd1 : work_pads;
    assign done     = (rem_mask == '0) && (rem_pads == '0);

    assign load = not_empty && (!out_valid_reg || out_ready);
    assign pop  = load && done;

    always_comb
    begin
        if (pick[vtae_pkg::SLOT_HIGH_Y])
        begin
            byte_next = vtae_pkg::SEL_HI | {2'b00, head.high_y};
        end
        else if (pick[vtae_pkg::SLOT_EXTRA])
        begin
            byte_next = vtae_pkg::SEL_LOY | {3'b000, head.extra};
        end
        else if (pick[vtae_pkg::SLOT_LOW_Y])
        begin
            byte_next = vtae_pkg::SEL_LOY | {2'b00, head.low_y};
        end
        else if (pick[vtae_pkg::SLOT_HIGH_X])
        begin
            byte_next = vtae_pkg::SEL_HI | {2'b00, head.high_x};
        end
        else if (pick[vtae_pkg::SLOT_LOW_X])
        begin
            byte_next = vtae_pkg::SEL_LOX | {2'b00, head.low_x};
        end
        else
        begin
            byte_next = vtae_pkg::PAD_BYTE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                started_reg   <= !done;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            mask_reg      <= rem_mask;
            pads_reg      <= rem_pads;
            out_byte_reg  <= byte_next;
            last_byte_reg <= done;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign last_byte = last_byte_reg;

    a_started_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |-> not_empty)
        else $error("command in progress but queue is empty");

    a_pop_marks_last: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (out_valid_reg && last_byte_reg && !started_reg))
        else $error("command retired without a last byte");

endmodule

FILE: verif/vtae_checker.sv
// checker for the vector terminal address encoder: predicts the byte stream and compares it
module vtae_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [11:0] x_coord,
    input  logic [11:0] y_coord,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [6:0]  out_byte,
    input  logic        last_byte,
    output int          errors,
    output int          pending,
    output int          bytes_checked
);

    typedef struct packed {
        logic [6:0] code;
        logic       last;
    } term_byte_t;

    term_byte_t byte_queue[$];

    // parts the terminal holds now, all-ones means nothing sent yet
    logic [5:0] term_high_x;
    logic [5:0] term_high_y;
    logic [5:0] term_low_y;
    logic [4:0] term_extra;

    function automatic int as_signed6(input logic [5:0] v);
        return v[5] ? int'(v) - 64 : int'(v);
    endfunction

    task automatic encode_point(input logic [11:0] x, input logic [11:0] y);
        logic [4:0] hx;
        logic [4:0] hy;
        logic [4:0] lx;
        logic [4:0] ly;
        logic [3:0] ex;
        int         dx;
        int         dy;
        int         dist2;
        int         npad;
        term_byte_t point_bytes[$];
        hx = x[11:7];
        hy = y[11:7];
        lx = x[6:2];
        ly = y[6:2];
        ex = {y[1:0], x[1:0]};
        dx = int'(hx) - as_signed6(term_high_x);
        dy = int'(hy) - as_signed6(term_high_y);
        dist2 = dx * dx + dy * dy;
        npad = int'(dist2 >= int'(vtae_pkg::PAD_TH1)) + int'(dist2 >= int'(vtae_pkg::PAD_TH2))
             + int'(dist2 >= int'(vtae_pkg::PAD_TH3)) + int'(dist2 >= int'(vtae_pkg::PAD_TH4));
        if ({1'b0, hy} != term_high_y)
        begin
            point_bytes.push_back('{code: {2'b00, hy} | vtae_pkg::SEL_HI, last: 1'b0});
            term_high_y = {1'b0, hy};
        end
        if ({1'b0, hx} != term_high_x)
        begin
            if ({1'b0, ex} != term_extra)
            begin
                point_bytes.push_back('{code: {3'b000, ex} | vtae_pkg::SEL_LOY, last: 1'b0});
                term_extra = {1'b0, ex};
            end
            point_bytes.push_back('{code: {2'b00, ly} | vtae_pkg::SEL_LOY, last: 1'b0});
            point_bytes.push_back('{code: {2'b00, hx} | vtae_pkg::SEL_HI, last: 1'b0});
            term_high_x = {1'b0, hx};
            term_low_y = {1'b0, ly};
        end
        else if ({1'b0, ex} != term_extra)
        begin
            point_bytes.push_back('{code: {3'b000, ex} | vtae_pkg::SEL_LOY, last: 1'b0});
            point_bytes.push_back('{code: {2'b00, ly} | vtae_pkg::SEL_LOY, last: 1'b0});
            term_extra = {1'b0, ex};
            term_low_y = {1'b0, ly};
        end
        else if ({1'b0, ly} != term_low_y)
        begin
            point_bytes.push_back('{code: {2'b00, ly} | vtae_pkg::SEL_LOY, last: 1'b0});
            term_low_y = {1'b0, ly};
        end
        point_bytes.push_back('{code: {2'b00, lx} | vtae_pkg::SEL_LOX, last: 1'b0});
        for (int i = 0; i < npad; i++)
            point_bytes.push_back('{code: vtae_pkg::PAD_BYTE, last: 1'b0});
        point_bytes[point_bytes.size() - 1].last = 1'b1;
        foreach (point_bytes[i])
            byte_queue.push_back(point_bytes[i]);
    endtask

    always @(posedge clk)
    begin
        term_byte_t want;
        if (!rst_n)
        begin
            term_high_x = vtae_pkg::NONE_SENT6;
            term_high_y = vtae_pkg::NONE_SENT6;
            term_low_y = vtae_pkg::NONE_SENT6;
            term_extra = vtae_pkg::NONE_SENT5;
            byte_queue.delete();
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                bytes_checked++;
                if (byte_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected byte, expected none, got %h last %b",
                             $time, out_byte, last_byte);
                end
                else
                begin
                    want = byte_queue.pop_front();
                    if (out_byte !== want.code)
                    begin
                        errors++;
                        $display("%0t: out_byte mismatch, expected %h, got %h",
                                 $time, want.code, out_byte);
                    end
                    if (last_byte !== want.last)
                    begin
                        errors++;
                        $display("%0t: last_byte mismatch, expected %b, got %b",
                                 $time, want.last, last_byte);
                    end
                end
            end
            if (in_valid && in_ready)
                encode_point(x_coord, y_coord);
        end
        pending = byte_queue.size();
    end

endmodule

FILE: verif/vector_terminal_address_encoder_top_tb.sv
// testbench top for the vector terminal address encoder: stimulus, stalls and verdict
module vector_terminal_address_encoder_top_tb;

    // clock and reset, all block inputs known from time zero
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [11:0] x_coord = '0;
    logic [11:0] y_coord = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [6:0]  out_byte;
    logic        last_byte;

    int errors;
    int pending;
    int bytes_checked;

    // stimulus bookkeeping
    bit          idle_on = 1'b1;
    int          points_sent = 0;
    int          directed_points = 0;
    logic [11:0] cur_x = '0;
    logic [11:0] cur_y = '0;

    vector_terminal_address_encoder_top i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .x_coord   (x_coord),
        .y_coord   (y_coord),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_byte  (out_byte),
        .last_byte (last_byte)
    );

    // watches both channels, predicts every byte and counts mismatches
    vtae_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .x_coord       (x_coord),
        .y_coord       (y_coord),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_byte      (out_byte),
        .last_byte     (last_byte),
        .errors        (errors),
        .pending       (pending),
        .bytes_checked (bytes_checked)
    );

    // 12 unit period
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver side: random stall bursts while idling is on, ready otherwise
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (idle_on && $urandom_range(0, 4) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 17)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    // one request on the input channel; may open with a random gap,
    // then holds valid and the point steady until in_ready is seen at an edge
    task automatic send_point(input logic [11:0] x, input logic [11:0] y);
        @(negedge clk);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clk);
        end
        in_valid = 1'b1;
        x_coord = x;
        y_coord = y;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        cur_x = x;
        cur_y = y;
        points_sent++;
    endtask

    // point built from its parts: high part, low part, two bottom bits
    task automatic send_parts(input logic [4:0] hx, input logic [4:0] lx, input logic [1:0] xb,
                              input logic [4:0] hy, input logic [4:0] ly, input logic [1:0] yb);
        send_point({hx, lx, xb}, {hy, ly, yb});
    endtask

    // stop sending and let every predicted byte come out
    task automatic drain_bytes();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
    endtask

    initial
    begin
        logic [4:0] hx;
        logic [4:0] hy;
        int         mode;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed part
        // first point after reset, far corner: every address byte plus four pads
        send_parts(31, 31, 3, 31, 31, 3);
        // long move back to the origin: three pads
        send_parts(0, 0, 0, 0, 0, 0);
        // same point again: only low x
        send_parts(0, 0, 0, 0, 0, 0);
        // only the extra bits change: extra, low y, low x
        send_parts(0, 0, 1, 0, 0, 0);
        // only low y changes
        send_parts(0, 0, 1, 0, 5, 0);
        // only low x changes
        send_parts(0, 7, 1, 0, 5, 0);
        // high x changes, extra held: low y, high x, low x
        send_parts(3, 7, 1, 0, 5, 0);
        // high x and extra change together
        send_parts(4, 7, 2, 0, 5, 0);
        // high y only, short move
        send_parts(4, 7, 2, 6, 5, 0);
        // squared move exactly at the first pad threshold, then just under it
        send_parts(8, 7, 2, 11, 5, 0);
        send_parts(10, 7, 2, 17, 5, 0);
        // exactly at the second threshold, then just under it
        send_parts(22, 7, 2, 2, 5, 0);
        send_parts(9, 7, 2, 16, 5, 0);
        // just under and just over the third threshold
        send_parts(0, 0, 0, 0, 0, 0);
        send_parts(31, 9, 1, 7, 9, 1);
        send_parts(0, 0, 0, 0, 0, 0);
        send_parts(31, 9, 1, 8, 9, 1);
        // coordinate extremes, one axis at a time and then both
        send_point(12'hFFF, 12'h000);
        send_point(12'h000, 12'hFFF);
        send_point(12'hFFF, 12'hFFF);
        directed_points = points_sent;

        // hold off until the encoder has emptied before the random part
        drain_bytes();

        // random part: mostly short moves as a plotter would send, some jumps,
        // repeated points and low-part-only changes to exercise suppression
        for (int n = 0; n < 200; n++)
        begin
            if (n == 100)
                drain_bytes();
            // last stretch runs with no idling on either side
            if (n == 150)
                idle_on = 1'b0;
            mode = $urandom_range(0, 9);
            hx = cur_x[11:7];
            hy = cur_y[11:7];
            if (mode <= 3)
            begin
                hx = hx + 5'($urandom_range(0, 6)) - 5'd3;
                hy = hy + 5'($urandom_range(0, 6)) - 5'd3;
                send_parts(hx, 5'($urandom), 2'($urandom), hy, 5'($urandom), 2'($urandom));
            end
            else if (mode <= 5)
                send_point(12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)));
            else if (mode <= 7)
                send_parts(hx, 5'($urandom), 2'($urandom), hy, 5'($urandom), 2'($urandom));
            else if (mode == 8)
                send_point(cur_x, cur_y);
            else
                send_point({cur_x[11:2], 2'($urandom)}, {cur_y[11:2], 2'($urandom)});
        end

        // wait out the remaining bytes, then keep the clock running to catch stray output
        drain_bytes();
        repeat (20) @(posedge clk);

        $display("covered %0d points (%0d directed), %0d bytes checked,",
                 points_sent, directed_points, bytes_checked);
        $display("pad runs up to four, byte suppression paths, stalls on both channels");
        if (errors == 0 && pending == 0)
            $display("vector_terminal_address_encoder_top_tb: done, clean");
        else
            $display("vector_terminal_address_encoder_top_tb: done, errors");
        $finish;
    end

    // watchdog, far beyond the slowest correct run
    initial
    begin
        #(12 * 400000);
        $display("vector_terminal_address_encoder_top_tb: done, errors");
        $finish;
    end

endmodule
